FILE: hw/rtl/frot_pkg.sv
// ---------------------------------------------------------------------------
// frot_pkg: shared types and constants for the planar frame rotation core
// Datapath widths, gain constant, arctangent table and pipeline item types.
// ---------------------------------------------------------------------------
`default_nettype none

package frot_pkg;

  // Rotation iterations: default and hard upper limit
  localparam int CORDIC_STAGES_DEF = 16;
  localparam int MAX_STAGES        = 32;

  // Guard bits kept below the Q16.16 point inside the rotator
  localparam int GUARD_BITS = 16;
  // Product width of the 32x32 gain multiply
  localparam int PROD_W     = 64;
  // Magnitude width after the gain multiply is scaled down
  localparam int MAG_W      = PROD_W - GUARD_BITS;
  // Rotator word: magnitude plus sign plus headroom for the CORDIC gain
  localparam int DATA_W     = MAG_W + 4;

  // 0.6072529350 in Q0.32
  localparam logic [31:0] GAIN_COMP = 32'd2608131496;

  // Direction command codes
  localparam logic CMD_G2L = 1'b0;
  localparam logic CMD_L2G = 1'b1;

  // One item in flight through the rotator
  typedef struct packed {
    logic signed [DATA_W-1:0] px;
    logic signed [DATA_W-1:0] py;
    logic signed [DATA_W-1:0] vx;
    logic signed [DATA_W-1:0] vy;
    logic        [31:0]       z;
    logic        [15:0]       heading;
    logic        [31:0]       yaw;
  } frot_pipe_t;

  // Finished result
  typedef struct packed {
    logic signed [31:0] px;
    logic signed [31:0] py;
    logic        [15:0] heading;
    logic signed [31:0] vx;
    logic signed [31:0] vy;
    logic        [31:0] yaw;
  } frot_res_t;

  // atan(2^-i) in 2^32-per-turn units
  function automatic logic [31:0] atan_lut(input logic [4:0] idx);
    logic [31:0] a;
    unique case (idx)
      5'd0:  a = 32'h20000000;
      5'd1:  a = 32'h12E4051E;
      5'd2:  a = 32'h09FB385B;
      5'd3:  a = 32'h051111D4;
      5'd4:  a = 32'h028B0D43;
      5'd5:  a = 32'h0145D7E1;
      5'd6:  a = 32'h00A2F61E;
      5'd7:  a = 32'h00517C55;
      5'd8:  a = 32'h0028BE53;
      5'd9:  a = 32'h00145F2F;
      5'd10: a = 32'h000A2F98;
      5'd11: a = 32'h000517CC;
      5'd12: a = 32'h00028BE6;
      5'd13: a = 32'h000145F3;
      5'd14: a = 32'h0000A2FA;
      5'd15: a = 32'h0000517D;
      5'd16: a = 32'h000028BE;
      5'd17: a = 32'h0000145F;
      5'd18: a = 32'h00000A30;
      5'd19: a = 32'h00000518;
      5'd20: a = 32'h0000028C;
      5'd21: a = 32'h00000146;
      5'd22: a = 32'h000000A3;
      5'd23: a = 32'h00000051;
      5'd24: a = 32'h00000029;
      5'd25: a = 32'h00000014;
      5'd26: a = 32'h0000000A;
      5'd27: a = 32'h00000005;
      5'd28: a = 32'h00000003;
      5'd29: a = 32'h00000001;
      5'd30: a = 32'h00000001;
      default: a = 32'h00000000;
    endcase
    return a;
  endfunction

endpackage

`default_nettype wire

FILE: hw/rtl/frot_prep.sv
// ---------------------------------------------------------------------------
// frot_prep: angle setup, quadrant fold and gain compensation
// Three register stages: fold, 32x32 gain multiply, round and re-sign.
// ---------------------------------------------------------------------------
`default_nettype none

module frot_prep
  import frot_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output      logic        in_ready_o,
  input  wire logic        cmd_i,
  input  wire logic [31:0] pos_x_i,
  input  wire logic [31:0] pos_y_i,
  input  wire logic [15:0] heading_i,
  input  wire logic [31:0] vel_x_i,
  input  wire logic [31:0] vel_y_i,
  input  wire logic [31:0] yaw_rate_i,
  output      logic        out_valid_o,
  input  wire logic        out_ready_i,
  output      frot_pipe_t  out_data_o
);

  typedef struct packed {
    logic [3:0]       neg;
    logic [3:0][31:0] mag;
    logic [31:0]      z;
    logic [15:0]      heading;
    logic [31:0]      yaw;
  } fold_t;

  typedef struct packed {
    logic [3:0]             neg;
    logic [3:0][PROD_W-1:0] prod;
    logic [31:0]            z;
    logic [15:0]            heading;
    logic [31:0]            yaw;
  } mult_t;

  logic       v1_q, v2_q, v3_q;
  logic       rdy1, rdy2, rdy3;
  fold_t      s1_d, s1_q;
  mult_t      s2_d, s2_q;
  frot_pipe_t s3_d, s3_q;

  assign rdy3       = !v3_q || out_ready_i;
  assign rdy2       = !v2_q || rdy3;
  assign rdy1       = !v1_q || rdy2;
  assign in_ready_o = rdy1;

  // Stage 1: angle, fold into [-90, +90) degrees, split sign and magnitude
  always_comb begin
    logic [31:0]       z;
    logic              fold;
    logic [3:0][31:0]  comp;
    logic signed [32:0] w;
    logic [32:0]       m;
    z = {heading_i, 16'h0000};
    if (cmd_i == CMD_G2L) begin
      z = 32'h0 - z;
    end
    fold = (z[31:30] == 2'b01) || (z[31:30] == 2'b10);
    comp[0] = pos_x_i;
    comp[1] = pos_y_i;
    comp[2] = vel_x_i;
    comp[3] = vel_y_i;
    for (int k = 0; k < 4; k++) begin
      w = {comp[k][31], comp[k]};
      if (fold) begin
        w = -w;
      end
      m = w[32] ? 33'(-w) : 33'(w);
      s1_d.neg[k] = w[32];
      s1_d.mag[k] = m[31:0];
    end
    s1_d.z       = fold ? (z + 32'h8000_0000) : z;
    s1_d.heading = heading_i;
    s1_d.yaw     = yaw_rate_i;
  end

  // Stage 2: gain multiply
  always_comb begin
    s2_d.neg = s1_q.neg;
    for (int k = 0; k < 4; k++) begin
      s2_d.prod[k] = PROD_W'(s1_q.mag[k]) * PROD_W'(GAIN_COMP);
    end
    s2_d.z       = s1_q.z;
    s2_d.heading = s1_q.heading;
    s2_d.yaw     = s1_q.yaw;
  end

  // Stage 3: round magnitude half away from zero, restore sign
  always_comb begin
    logic [PROD_W-1:0]        sum;
    logic signed [DATA_W-1:0] val [4];
    for (int k = 0; k < 4; k++) begin
      sum    = s2_q.prod[k] + (PROD_W'(1) << (GUARD_BITS - 1));
      val[k] = $signed({{(DATA_W - MAG_W){1'b0}}, sum[PROD_W-1:GUARD_BITS]});
      if (s2_q.neg[k]) begin
        val[k] = -val[k];
      end
    end
    s3_d.px      = val[0];
    s3_d.py      = val[1];
    s3_d.vx      = val[2];
    s3_d.vy      = val[3];
    s3_d.z       = s2_q.z;
    s3_d.heading = s2_q.heading;
    s3_d.yaw     = s2_q.yaw;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      if (rdy1) v1_q <= in_valid_i;
      if (rdy2) v2_q <= v1_q;
      if (rdy3) v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy1 && in_valid_i) s1_q <= s1_d;
    if (rdy2 && v1_q)       s2_q <= s2_d;
    if (rdy3 && v2_q)       s3_q <= s3_d;
  end

  assign out_valid_o = v3_q;
  assign out_data_o  = s3_q;

endmodule

`default_nettype wire

FILE: hw/rtl/frot_cordic_stage.sv
// ---------------------------------------------------------------------------
// frot_cordic_stage: one CORDIC micro-rotation, registered
// Rotates both vectors by the same direction, picked from the sign of z.
// ---------------------------------------------------------------------------
`default_nettype none

module frot_cordic_stage
  import frot_pkg::*;
#(
  parameter int SHIFT = 0
) (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       in_valid_i,
  output      logic       in_ready_o,
  input  wire frot_pipe_t in_data_i,
  output      logic       out_valid_o,
  input  wire logic       out_ready_i,
  output      frot_pipe_t out_data_o
);

  localparam logic [31:0] ANGLE = atan_lut(5'(SHIFT));

  logic       vld_q;
  logic       rdy;
  frot_pipe_t data_d, data_q;

  assign rdy        = !vld_q || out_ready_i;
  assign in_ready_o = rdy;

  always_comb begin
    data_d = in_data_i;
    if (!in_data_i.z[31]) begin
      data_d.px = in_data_i.px - (in_data_i.py >>> SHIFT);
      data_d.py = in_data_i.py + (in_data_i.px >>> SHIFT);
      data_d.vx = in_data_i.vx - (in_data_i.vy >>> SHIFT);
      data_d.vy = in_data_i.vy + (in_data_i.vx >>> SHIFT);
      data_d.z  = in_data_i.z - ANGLE;
    end else begin
      data_d.px = in_data_i.px + (in_data_i.py >>> SHIFT);
      data_d.py = in_data_i.py - (in_data_i.px >>> SHIFT);
      data_d.vx = in_data_i.vx + (in_data_i.vy >>> SHIFT);
      data_d.vy = in_data_i.vy - (in_data_i.vx >>> SHIFT);
      data_d.z  = in_data_i.z + ANGLE;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (rdy) begin
      vld_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy && in_valid_i) data_q <= data_d;
  end

  assign out_valid_o = vld_q;
  assign out_data_o  = data_q;

endmodule

`default_nettype wire

FILE: hw/rtl/frot_finish.sv
// ---------------------------------------------------------------------------
// frot_finish: drop guard bits and saturate, output register
// Rounds half up, clamps each component to the signed 32-bit range.
// ---------------------------------------------------------------------------
`default_nettype none

module frot_finish
  import frot_pkg::*;
(
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       in_valid_i,
  output      logic       in_ready_o,
  input  wire frot_pipe_t in_data_i,
  output      logic       out_valid_o,
  input  wire logic       out_ready_i,
  output      frot_res_t  out_data_o
);

  localparam int SH_W = DATA_W - GUARD_BITS;

  function automatic logic [31:0] round_sat(input logic signed [DATA_W-1:0] v);
    logic [DATA_W-1:0] sum;
    logic [SH_W-1:0]   sh;
    logic [31:0]       r;
    sum = v + (DATA_W'(1) << (GUARD_BITS - 1));
    sh  = sum[DATA_W-1:GUARD_BITS];
    if (!sh[SH_W-1] && (|sh[SH_W-2:31])) begin
      r = 32'h7FFF_FFFF;
    end else if (sh[SH_W-1] && !(&sh[SH_W-2:31])) begin
      r = 32'h8000_0000;
    end else begin
      r = sh[31:0];
    end
    return r;
  endfunction

  logic      vld_q;
  logic      rdy;
  frot_res_t data_d, data_q;

  assign rdy        = !vld_q || out_ready_i;
  assign in_ready_o = rdy;

  always_comb begin
    data_d.px      = round_sat(in_data_i.px);
    data_d.py      = round_sat(in_data_i.py);
    data_d.heading = in_data_i.heading;
    data_d.vx      = round_sat(in_data_i.vx);
    data_d.vy      = round_sat(in_data_i.vy);
    data_d.yaw     = in_data_i.yaw;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (rdy) begin
      vld_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy && in_valid_i) data_q <= data_d;
  end

  assign out_valid_o = vld_q;
  assign out_data_o  = data_q;

endmodule

`default_nettype wire

FILE: hw/rtl/planar_frame_rotation_core.sv
// ---------------------------------------------------------------------------
// planar_frame_rotation_core: pose and twist frame rotation
// Rotates position and velocity by the heading with a gain-compensated,
// fully pipelined CORDIC; heading and yaw rate pass through.
// ---------------------------------------------------------------------------
//
//  Channel   Dir  Payload                                       Notes
//  s_axis    in   tdata 176b: pos_x, pos_y, heading, vel_x,      request per
//                 vel_y, yaw_rate; tuser 1b: cmd                 cycle unless stalled
//  m_axis    out  tdata 176b: pos_x, pos_y, heading, vel_x,      one result
//                 vel_y, yaw_rate                                per request
//
//  Register stages in order: fold, gain multiply, round, the micro-rotations
//  (at most MAX_STAGES), then round and saturate.
//  One request is taken every cycle unless back-pressure holds s_axis_tready
//  low; the gain multiply and each micro-rotation are separate register stages.
//  Every stage has its own valid bit and a local ready, so an output stall
//  fills bubbles upstream before back-pressure reaches s_axis_tready.
//  rst_ni clears only valid bits; payload registers are not reset.
// ---------------------------------------------------------------------------
`default_nettype none

module planar_frame_rotation_core
  import frot_pkg::*;
#(
  parameter int CORDIC_STAGES = CORDIC_STAGES_DEF
) (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  // Input requests
  input  wire logic         s_axis_tvalid,
  output      logic         s_axis_tready,
  // [31:0] pos_x_in, [63:32] pos_y_in, [79:64] heading_in,
  // [111:80] vel_x_in, [143:112] vel_y_in, [175:144] yaw_rate_in
  input  wire logic [175:0] s_axis_tdata,
  // [0] cmd
  input  wire logic [0:0]   s_axis_tuser,
  // Results
  output      logic         m_axis_tvalid,
  input  wire logic         m_axis_tready,
  // [31:0] pos_x_out, [63:32] pos_y_out, [79:64] heading_out,
  // [111:80] vel_x_out, [143:112] vel_y_out, [175:144] yaw_rate_out
  output      logic [175:0] m_axis_tdata
);

  // Iterations beyond MAX_STAGES are not performed
  localparam int NUM_ROT = (CORDIC_STAGES > MAX_STAGES) ? MAX_STAGES : CORDIC_STAGES;

  logic       pipe_vld [NUM_ROT+1];
  logic       pipe_rdy [NUM_ROT+1];
  frot_pipe_t pipe_dat [NUM_ROT+1];

  logic       fin_vld;
  frot_res_t  fin_dat;

  // Angle setup, quadrant fold, gain compensation
  frot_prep u_prep (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .cmd_i       (s_axis_tuser[0]),
    .pos_x_i     (s_axis_tdata[31:0]),
    .pos_y_i     (s_axis_tdata[63:32]),
    .heading_i   (s_axis_tdata[79:64]),
    .vel_x_i     (s_axis_tdata[111:80]),
    .vel_y_i     (s_axis_tdata[143:112]),
    .yaw_rate_i  (s_axis_tdata[175:144]),
    .out_valid_o (pipe_vld[0]),
    .out_ready_i (pipe_rdy[0]),
    .out_data_o  (pipe_dat[0])
  );

  // Micro-rotation chain, one register stage per iteration
  for (genvar i = 0; i < NUM_ROT; i++) begin : g_rot
    frot_cordic_stage #(
      .SHIFT (i)
    ) u_stage (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .in_valid_i  (pipe_vld[i]),
      .in_ready_o  (pipe_rdy[i]),
      .in_data_i   (pipe_dat[i]),
      .out_valid_o (pipe_vld[i+1]),
      .out_ready_i (pipe_rdy[i+1]),
      .out_data_o  (pipe_dat[i+1])
    );
  end

  // Round, saturate, output register
  frot_finish u_finish (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (pipe_vld[NUM_ROT]),
    .in_ready_o  (pipe_rdy[NUM_ROT]),
    .in_data_i   (pipe_dat[NUM_ROT]),
    .out_valid_o (fin_vld),
    .out_ready_i (m_axis_tready),
    .out_data_o  (fin_dat)
  );

  assign m_axis_tvalid = fin_vld;
  assign m_axis_tdata  = {fin_dat.yaw, fin_dat.vy, fin_dat.vx,
                          fin_dat.heading, fin_dat.py, fin_dat.px};

endmodule

`default_nettype wire
